// ----- rtl/skt_pkg.sv -----
package skt_pkg;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DROPPED   = 2'd2;

  localparam int KEY_W   = 16;
  localparam int ITEMS_W = 8;
  localparam int TIME_W  = 11;
  localparam int OCC_W   = 6;

  typedef struct packed {
    logic [TIME_W-1:0]  etime;
    logic [ITEMS_W-1:0] items;
    logic [KEY_W-1:0]   key;
  } entry_t;

  // broadcast to every cell
  typedef struct packed {
    logic   cmp_en;
    logic   ins_en;
    logic   del_en;
    entry_t entry;
  } ctl_t;

  typedef enum logic [0:0] {
    SK_IDLE  = 1'b0,
    SK_APPLY = 1'b1
  } state_t;

endpackage

// ----- rtl/skt_cell.sv -----
module skt_cell (
  input  logic          clk,
  input  skt_pkg::ctl_t ctl,
  input  logic          valid_i,
  input  logic          prev_shift,
  input  skt_pkg::entry_t prev_entry,
  input  skt_pkg::entry_t next_entry,
  output skt_pkg::entry_t entry_o,
  output logic          gt_o,
  output logic          ge_o,
  output logic          eq_o
);

  skt_pkg::entry_t entry_r, entry_nxt;
  logic            gt_r, ge_r, eq_r;

  // compare flags, taken on the transfer cycle
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      gt_r <= !valid_i || (entry_r.key > ctl.entry.key);
      ge_r <= valid_i && (entry_r.key >= ctl.entry.key);
      eq_r <= valid_i && (entry_r.key == ctl.entry.key);
    end
  end

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins_en) begin
      if (prev_shift) begin
        entry_nxt = prev_entry;
      end else if (gt_r) begin
        entry_nxt = ctl.entry;
      end
    end else if (ctl.del_en && ge_r) begin
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;
  assign gt_o    = gt_r;
  assign ge_o    = ge_r;
  assign eq_o    = eq_r;

endmodule

// ----- rtl/sorted_key_table.sv -----
// sorted key table: entries kept in ascending key order in a row of cells
// operation: a compare step on the input transfer, then a shift step of the
// cell row that loads the result register; a new operation is taken only
// after the shift step, and a stalled result holds the shift step
// reset: rst_n synchronous active low; occupancy goes to zero (table empty),
// cell contents are not cleared, cells at or above the occupancy never show
module sorted_key_table #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // key[15:0], item_count[23:16], entry_time[34:24], zero pad
  input  logic [0:0]  in_tuser,   // op[0]
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // head_key[15:0], head_items[23:16], head_time[34:24],
                                  // is_empty[35], is_full[36], occupancy[42:37], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);

  localparam int CW = $clog2(DEPTH + 1);

  // fsm and held operation
  skt_pkg::state_t state_r, state_nxt;
  skt_pkg::op_t    op_r;
  skt_pkg::entry_t new_r;
  skt_pkg::entry_t in_entry;

  // occupancy
  logic [CW-1:0] count_r, count_nxt;

  // cell row wiring
  skt_pkg::ctl_t   ctl;
  skt_pkg::entry_t cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_gt, cell_ge, cell_eq, cell_valid;

  // control
  logic in_xfer, cmp_en, apply, out_free, found, is_full_now;
  logic do_ins, do_del;

  // result register
  logic            out_valid_r;
  logic [1:0]      out_status_r, status_nxt;
  skt_pkg::entry_t head_nxt;
  logic [47:0]     out_data_r, out_data_nxt;

  assign in_entry.key   = in_tdata[15:0];
  assign in_entry.items = in_tdata[23:16];
  assign in_entry.etime = in_tdata[34:24];

  assign in_xfer     = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign found       = |cell_eq;
  assign is_full_now = (count_r == CW'(DEPTH));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      skt_pkg::SK_IDLE:  if (in_xfer)  state_nxt = skt_pkg::SK_APPLY;
      skt_pkg::SK_APPLY: if (out_free) state_nxt = skt_pkg::SK_IDLE;
      default:           state_nxt = skt_pkg::SK_IDLE;
    endcase
  end

  // fsm outputs; no transfer is taken while reset is held
  always_comb begin
    in_tready = 1'b0;
    cmp_en    = 1'b0;
    apply     = 1'b0;
    case (state_r)
      skt_pkg::SK_IDLE: begin
        in_tready = rst_n;
        cmp_en    = in_tvalid && rst_n;
      end
      skt_pkg::SK_APPLY: begin
        apply = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= skt_pkg::SK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the operation for the shift step
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= skt_pkg::op_t'(in_tuser[0]);
      new_r <= in_entry;
    end
  end

  // a full table drops an insert, a missing key leaves the table alone
  assign do_ins = apply && (op_r == skt_pkg::OP_INSERT) && !is_full_now;
  assign do_del = apply && (op_r == skt_pkg::OP_DELETE) && found;

  // the compare step sees the entry on the bus, the shift step the held one
  assign ctl.cmp_en = cmp_en;
  assign ctl.ins_en = do_ins;
  assign ctl.del_en = do_del;
  assign ctl.entry  = (state_r == skt_pkg::SK_IDLE) ? in_entry : new_r;

  // row of cells; cell i is live when it sits below the occupancy
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    skt_pkg::entry_t prev_e, next_e;
    logic            prev_s;

    assign cell_valid[i] = (CW'(i) < count_r);

    if (i == 0) begin : g_first
      assign prev_s = 1'b0;
      assign prev_e = new_r;
    end else begin : g_mid
      assign prev_s = cell_gt[i-1];
      assign prev_e = cell_entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_e = new_r;
    end else begin : g_body
      assign next_e = cell_entry[i+1];
    end

    skt_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid_i    (cell_valid[i]),
      .prev_shift (prev_s),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry_o    (cell_entry[i]),
      .gt_o       (cell_gt[i]),
      .ge_o       (cell_ge[i]),
      .eq_o       (cell_eq[i])
    );
  end

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + CW'(1);
    end else if (do_del) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // head after the shift, worked out from the two lowest cells
  always_comb begin
    head_nxt   = cell_entry[0];
    status_nxt = skt_pkg::ST_DONE;
    if (op_r == skt_pkg::OP_INSERT) begin
      if (is_full_now) begin
        status_nxt = skt_pkg::ST_DROPPED;
      end else if (cell_gt[0]) begin
        head_nxt = new_r;
      end
    end else begin
      if (!found) begin
        status_nxt = skt_pkg::ST_NOT_FOUND;
      end else if (cell_ge[0]) begin
        head_nxt = cell_entry[1];
      end
    end
    if (count_nxt == '0) begin
      head_nxt = '0;
    end
  end

  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt[15:0]  = head_nxt.key;
    out_data_nxt[23:16] = head_nxt.items;
    out_data_nxt[34:24] = head_nxt.etime;
    out_data_nxt[35]    = (count_nxt == '0);
    out_data_nxt[36]    = (count_nxt == CW'(DEPTH));
    out_data_nxt[42:37] = skt_pkg::OCC_W'(count_nxt);
  end

  // result register parts the two channels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (apply) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply) begin
      out_status_r <= status_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

`ifndef SYNTHESIS
  // occupancy never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy above depth");

  // occupancy moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)))
    else $error("occupancy jumped");

  // an accepted transfer always goes on to the shift step
  a_xfer_apply: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == skt_pkg::SK_APPLY))
    else $error("transfer not followed by shift step");

  // a dropped insert only happens on a full table
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == skt_pkg::ST_DROPPED)) |-> out_tdata[36])
    else $error("insert dropped while not full");
`endif

endmodule

// ----- test/sorted_key_table_tb.sv -----
`timescale 1ns / 100ps

module sorted_key_table_tb;

  localparam int DEPTH       = 32;
  localparam int RANDOM_OPS  = 1600;
  // cycles with no transfer on either channel before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // drain time after the last result
  localparam int TAIL_CYCLES = 10;

  // one result as seen on the result channel
  typedef struct packed {
    logic [1:0]                  status;
    logic [skt_pkg::KEY_W-1:0]   head_key;
    logic [skt_pkg::ITEMS_W-1:0] head_items;
    logic [skt_pkg::TIME_W-1:0]  head_time;
    logic                        is_empty;
    logic                        is_full;
    logic [skt_pkg::OCC_W-1:0]   occupancy;
  } table_view_t;

  // one row of the directed plan; typed rows carry their result
  typedef struct packed {
    skt_pkg::op_t                op;
    logic [skt_pkg::KEY_W-1:0]   key;
    logic [skt_pkg::ITEMS_W-1:0] items;
    logic [skt_pkg::TIME_W-1:0]  etime;
    logic                        typed;
    table_view_t                 want;
  } plan_row_t;

  localparam int PLAN_LEN = 13;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // delete on the empty table: not found, zero head
    '{skt_pkg::OP_DELETE, 16'h0000, 8'h00, 11'h000, 1'b1,
      '{skt_pkg::ST_NOT_FOUND, 16'h0000, 8'h00, 11'h000, 1'b1, 1'b0, 6'd0}},
    // largest key and payload
    '{skt_pkg::OP_INSERT, 16'hFFFF, 8'hFF, 11'h7FF, 1'b1,
      '{skt_pkg::ST_DONE, 16'hFFFF, 8'hFF, 11'h7FF, 1'b0, 1'b0, 6'd1}},
    // smallest key and payload becomes the head
    '{skt_pkg::OP_INSERT, 16'h0000, 8'h00, 11'h000, 1'b1,
      '{skt_pkg::ST_DONE, 16'h0000, 8'h00, 11'h000, 1'b0, 1'b0, 6'd2}},
    '{skt_pkg::OP_INSERT, 16'h8000, 8'hAA, 11'h555, 1'b0, '0},
    // equal key goes behind the one already held
    '{skt_pkg::OP_INSERT, 16'h0000, 8'h55, 11'h2AA, 1'b0, '0},
    '{skt_pkg::OP_INSERT, 16'hFFFF, 8'h01, 11'h001, 1'b0, '0},
    // removes the older zero key, the newer one moves to the head
    '{skt_pkg::OP_DELETE, 16'h0000, 8'h00, 11'h000, 1'b0, '0},
    // miss; payload fields of a delete are don't care
    '{skt_pkg::OP_DELETE, 16'h1234, 8'hFF, 11'h7FF, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 16'hFFFF, 8'h5A, 11'h3C3, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 16'h0000, 8'h00, 11'h000, 1'b0, '0},
    '{skt_pkg::OP_DELETE, 16'h8000, 8'h00, 11'h000, 1'b0, '0},
    // last entry leaves, back to empty
    '{skt_pkg::OP_DELETE, 16'hFFFF, 8'h00, 11'h000, 1'b1,
      '{skt_pkg::ST_DONE, 16'h0000, 8'h00, 11'h000, 1'b1, 1'b0, 6'd0}},
    '{skt_pkg::OP_DELETE, 16'hFFFF, 8'h00, 11'h000, 1'b1,
      '{skt_pkg::ST_NOT_FOUND, 16'h0000, 8'h00, 11'h000, 1'b1, 1'b0, 6'd0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // key[15:0], item_count[23:16], entry_time[34:24], zero pad
  logic [0:0]  in_tuser;   // op[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // head_key[15:0], head_items[23:16], head_time[34:24],
                           // is_empty[35], is_full[36], occupancy[42:37], zero pad
  logic [1:0]  out_tuser;  // status[1:0]

  sorted_key_table #(.DEPTH(DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // shadow copy of the table, kept sorted like the block
  skt_pkg::entry_t shadow_rows [DEPTH];
  int              shadow_fill;

  // results still owed by the block, oldest first
  table_view_t pending_views [$];

  int error_count;
  int ops_sent;
  int quiet_cycles;
  int sink_hold;
  bit source_steady;
  bit sink_steady;

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // table model: apply one operation, return the view after it
  // ---------------------------------------------------------------------------
  function automatic table_view_t table_apply(skt_pkg::op_t op, skt_pkg::entry_t e);
    table_view_t v;
    int pos;
    v = '0;
    v.status = skt_pkg::ST_DONE;
    pos = 0;
    if (op == skt_pkg::OP_INSERT) begin
      if (shadow_fill >= DEPTH) begin
        v.status = skt_pkg::ST_DROPPED;
      end else begin
        // stable: new entry lands after every key <= its own
        while (pos < shadow_fill && shadow_rows[pos].key <= e.key) pos++;
        for (int i = shadow_fill; i > pos; i--) shadow_rows[i] = shadow_rows[i-1];
        shadow_rows[pos] = e;
        shadow_fill++;
      end
    end else begin
      // first match in table order
      while (pos < shadow_fill && shadow_rows[pos].key != e.key) pos++;
      if (pos >= shadow_fill) begin
        v.status = skt_pkg::ST_NOT_FOUND;
      end else begin
        for (int i = pos; i + 1 < shadow_fill; i++) shadow_rows[i] = shadow_rows[i+1];
        shadow_fill--;
      end
    end
    if (shadow_fill > 0) begin
      v.head_key   = shadow_rows[0].key;
      v.head_items = shadow_rows[0].items;
      v.head_time  = shadow_rows[0].etime;
    end
    v.is_empty  = (shadow_fill == 0);
    v.is_full   = (shadow_fill >= DEPTH);
    v.occupancy = shadow_fill[skt_pkg::OCC_W-1:0];
    return v;
  endfunction

  // idle length: mostly none, often short, rarely long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // keys that collide often, sit at the top end, hit held entries, or are anything
  function automatic logic [skt_pkg::KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return skt_pkg::KEY_W'($urandom_range(0, 7));
    if (r < 30) return 16'hFFFF - skt_pkg::KEY_W'($urandom_range(0, 3));
    if (r < 65 && shadow_fill > 0) return shadow_rows[$urandom_range(0, shadow_fill - 1)].key;
    return skt_pkg::KEY_W'($urandom);
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("mismatch @%0t: %s got 0x%0h expected 0x%0h", $realtime, field, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // input side: one operation, gap first, valid held until the transfer
  // ---------------------------------------------------------------------------
  task automatic send_op(skt_pkg::op_t op, logic [skt_pkg::KEY_W-1:0] key,
                         logic [skt_pkg::ITEMS_W-1:0] items,
                         logic [skt_pkg::TIME_W-1:0] etime, bit typed, table_view_t want);
    int gap;
    skt_pkg::entry_t e;
    table_view_t v;
    gap = source_steady ? 0 : gap_len();
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, etime, items, key};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    // transfer taken at this edge
    e.key   = key;
    e.items = items;
    e.etime = etime;
    v = table_apply(op, e);
    pending_views.push_back(typed ? want : v);
    ops_sent++;
  endtask

  task automatic random_op(int insert_pct);
    skt_pkg::op_t op;
    op = ($urandom_range(0, 99) < insert_pct) ? skt_pkg::OP_INSERT : skt_pkg::OP_DELETE;
    send_op(op, pick_key(), skt_pkg::ITEMS_W'($urandom), skt_pkg::TIME_W'($urandom),
            1'b0, '0);
  endtask

  // hold off the sender until every result is back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random back-pressure, applied at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      out_tready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 3) == 0) begin
      sink_hold = gap_len();
      out_tready <= (sink_hold == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: every result transfer against the oldest owed view
  always @(posedge clk) begin
    table_view_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_views.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_tdata[42:0]), 64'd0);
      end else begin
        want = pending_views.pop_front();
        if (out_tuser != want.status)
          report_mismatch("status", 64'(out_tuser), 64'(want.status));
        if (out_tdata[15:0] != want.head_key)
          report_mismatch("head_key", 64'(out_tdata[15:0]), 64'(want.head_key));
        if (out_tdata[23:16] != want.head_items)
          report_mismatch("head_items", 64'(out_tdata[23:16]), 64'(want.head_items));
        if (out_tdata[34:24] != want.head_time)
          report_mismatch("head_time", 64'(out_tdata[34:24]), 64'(want.head_time));
        if (out_tdata[35] != want.is_empty)
          report_mismatch("is_empty", 64'(out_tdata[35]), 64'(want.is_empty));
        if (out_tdata[36] != want.is_full)
          report_mismatch("is_full", 64'(out_tdata[36]), 64'(want.is_full));
        if (out_tdata[42:37] != want.occupancy)
          report_mismatch("occupancy", 64'(out_tdata[42:37]), 64'(want.occupancy));
        if (out_tdata[47:43] != 5'b0)
          report_mismatch("pad", 64'(out_tdata[47:43]), 64'd0);
      end
    end
  end

  // watchdog: too long with no transfer on either side ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("sorted_key_table_tb: FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int plen;
    int pct;
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    error_count   = 0;
    ops_sent      = 0;
    quiet_cycles  = 0;
    sink_hold     = 0;
    source_steady = 1'b0;
    sink_steady   = 1'b0;
    shadow_fill   = 0;
    for (int i = 0; i < DEPTH; i++) shadow_rows[i] = '0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed plan: extremes, ties, misses, empty table
    for (int i = 0; i < PLAN_LEN; i++)
      send_op(PLAN[i].op, PLAN[i].key, PLAN[i].items, PLAN[i].etime,
              PLAN[i].typed, PLAN[i].want);

    // fill past full so inserts get dropped, then drain back to empty
    for (int i = 0; i < DEPTH + 4; i++)
      send_op(skt_pkg::OP_INSERT, pick_key(), skt_pkg::ITEMS_W'($urandom),
              skt_pkg::TIME_W'($urandom), 1'b0, '0);
    wait_drained();
    source_steady = 1'b1;
    sink_steady   = 1'b1;
    while (shadow_fill > 0)
      send_op(skt_pkg::OP_DELETE, shadow_rows[$urandom_range(0, shadow_fill - 1)].key,
              skt_pkg::ITEMS_W'($urandom), skt_pkg::TIME_W'($urandom), 1'b0, '0);
    source_steady = 1'b0;
    sink_steady   = 1'b0;

    // random phases; the insert share moves the fill level up and down
    ops_sent = 0;
    while (ops_sent < RANDOM_OPS) begin
      plen          = $urandom_range(30, 120);
      pct           = 10 + 20 * $urandom_range(0, 4);
      source_steady = ($urandom_range(0, 4) == 0);
      sink_steady   = ($urandom_range(0, 4) == 0);
      repeat (plen) random_op(pct);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_views.size() == 0) begin
      $display("sorted_key_table_tb: PASS");
    end else begin
      $display("sorted_key_table_tb: FAIL");
    end
    $finish;
  end

endmodule
